// ----- hdl/pds_pkg.sv -----
package pds_pkg;

  localparam int REM_W   = 13;
  localparam int DIGIT_W = 4;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd100;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_NEXT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [IDX_W-1:0]   digit_index;
    logic               last_digit;
    logic               rippled;
    logic               bad_request;
  } out_t;

endpackage

// ----- hdl/pds_ram.sv -----
module pds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pi_digit_spigot.sv -----
// Decimal digits of pi by the Rabinowitz-Wagon spigot. func 0 starts a run of
// cfg_data digits (clamped to 1..MAX_DIGITS, latched at start): it writes 2 into
// every remainder, one entry a cycle. func 1 produces the next digit: the sweep
// visits each of the run's (10*n+2)/3 remainders in turn, one memory read, one
// restoring divide of SW (= clog2(REMAINDER_DEPTH)+8, 20 by default) quotient
// bits and one write back each; when a carry ripples back, stored digits are
// read and rewritten from the newest back, a nine turning to zero, until one
// below nine or the first digit takes the carry. func 2 reads a stored digit.
// Refused transactions answer with bad_request set. One transaction is in work
// at a time; a new one is taken while the last result still waits in the
// output register.
module pi_digit_spigot #(
  parameter int MAX_DIGITS      = 1024,
  parameter int REMAINDER_DEPTH = 3414
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pds_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pds_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pds_pkg::out_t               out_data
);

  localparam int DAW = $clog2(MAX_DIGITS);
  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int RAW = $clog2(REMAINDER_DEPTH);
  localparam int LW  = $clog2(REMAINDER_DEPTH + 1);
  localparam int MW  = RAW + 1;
  localparam int SW  = RAW + 8;
  localparam int CNW = $clog2(SW);
  localparam int XW  = $clog2(10 * MAX_DIGITS + 3);
  localparam int S3  = XW + 1;
  localparam int RECIP3 = (2 ** S3 + 2) / 3;
  localparam int TOT_CLAMP = (3 * REMAINDER_DEPTH) / 10;

  localparam pds_pkg::out_t RES_BAD = '{bad_request: 1'b1, default: '0};

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_FILL     = 12'b000000000010,
    S_SW_RD    = 12'b000000000100,
    S_SW_SUM   = 12'b000000001000,
    S_SW_DIV   = 12'b000000010000,
    S_SW_WB    = 12'b000000100000,
    S_RIP_RD   = 12'b000001000000,
    S_RIP_WR   = 12'b000010000000,
    S_DIG_WR   = 12'b000100000000,
    S_RD_ISSUE = 12'b001000000000,
    S_RD_TAKE  = 12'b010000000000,
    S_PUSH     = 12'b100000000000
  } state_t;

  state_t state;

  logic [pds_pkg::CFG_W-1:0]   digit_total;
  logic                        run_active;
  logic [DCW-1:0]              digits_made;
  logic [LW-1:0]               sweep_length;
  logic [DCW-1:0]              total;
  logic [RAW-1:0]              fill_addr;
  logic [RAW-1:0]              j;
  logic [SW-1:0]               carry;
  logic [SW-1:0]               quo;
  logic [MW-1:0]               r;
  logic [MW-1:0]               modulus;
  logic [CNW-1:0]              cnt;
  logic [DAW-1:0]              k;
  logic [DAW-1:0]              pos;
  logic [DAW-1:0]              rd_addr;
  logic [pds_pkg::DIGIT_W-1:0] qd;
  logic                        rip;
  pds_pkg::out_t               res;

  // remainder memory
  logic                      rem_we;
  logic [RAW-1:0]            rem_waddr;
  logic [pds_pkg::REM_W-1:0] rem_wdata;
  logic [pds_pkg::REM_W-1:0] rem_rdata;

  // digit memory
  logic                        st_we;
  logic [DAW-1:0]              st_waddr;
  logic [pds_pkg::DIGIT_W-1:0] st_wdata;
  logic [DAW-1:0]              st_raddr;
  logic [pds_pkg::DIGIT_W-1:0] st_rdata;

  assign rem_we    = (state == S_FILL) || (state == S_SW_WB);
  assign rem_waddr = (state == S_FILL) ? fill_addr : j;
  assign rem_wdata = (state == S_FILL) ? pds_pkg::REM_W'(2) : pds_pkg::REM_W'(r);

  pds_ram #(.WIDTH(pds_pkg::REM_W), .DEPTH(REMAINDER_DEPTH)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (j),
    .rdata (rem_rdata)
  );

  assign st_we    = (state == S_RIP_WR) || (state == S_DIG_WR);
  assign st_waddr = (state == S_RIP_WR) ? k : pos;
  always_comb begin
    if (state == S_RIP_WR) begin
      st_wdata = (st_rdata == pds_pkg::DIGIT_W'(9)) ? '0 : st_rdata + 1'b1;
    end else begin
      st_wdata = qd;
    end
  end
  assign st_raddr = (state == S_RIP_RD) ? k : rd_addr;

  pds_ram #(.WIDTH(pds_pkg::DIGIT_W), .DEPTH(MAX_DIGITS)) u_digit_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // run length at start: n clamped, m = (10n+2)/3 by reciprocal, run total
  logic [DCW-1:0]     n_val;
  logic [XW-1:0]      x_val;
  logic [XW+S3-1:0]   m_prod;
  logic [XW-1:0]      m_raw;
  logic               m_clamped;
  logic [LW-1:0]      m_val;
  logic [DCW-1:0]     total_val;

  always_comb begin
    if (digit_total == '0) begin
      n_val = DCW'(1);
    end else if (32'(digit_total) > MAX_DIGITS) begin
      n_val = DCW'(MAX_DIGITS);
    end else begin
      n_val = DCW'(digit_total);
    end
    x_val     = XW'(n_val) * XW'(10) + XW'(2);
    m_prod    = (XW+S3)'(x_val) * (XW+S3)'(RECIP3);
    m_raw     = m_prod[XW+S3-1:S3];
    m_clamped = 32'(m_raw) > REMAINDER_DEPTH;
    m_val     = m_clamped ? LW'(REMAINDER_DEPTH) : LW'(m_raw);
    // unclamped, (3*m)/10 equals n exactly
    total_val = m_clamped ? DCW'(TOT_CLAMP) : n_val;
  end

  // divider step and digit fix-up
  logic [MW:0]   r_shift;
  logic          r_ge;
  logic [SW-1:0] q_adj;

  assign r_shift = {r, quo[SW-1]};
  assign r_ge    = r_shift >= {1'b0, modulus};
  assign q_adj   = (quo >= SW'(10)) ? quo - SW'(10) : quo;

  logic in_fire;
  logic push;
  assign in_fire  = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_PUSH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_total <= pds_pkg::CFG_RESET;
    end else if (cfg_write) begin
      digit_total <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_active   <= 1'b0;
      digits_made  <= '0;
      sweep_length <= '0;
      total        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.func)
              pds_pkg::FUNC_START: begin
                res          <= '0;
                sweep_length <= m_val;
                total        <= total_val;
                digits_made  <= '0;
                run_active   <= 1'b1;
                fill_addr    <= '0;
                state        <= S_FILL;
              end
              pds_pkg::FUNC_NEXT: begin
                if (!run_active || digits_made >= total ||
                    32'(digits_made) >= MAX_DIGITS) begin
                  res   <= RES_BAD;
                  state <= S_PUSH;
                end else begin
                  res   <= '0;
                  j     <= RAW'(sweep_length - 1'b1);
                  carry <= '0;
                  pos   <= DAW'(digits_made);
                  state <= S_SW_RD;
                end
              end
              pds_pkg::FUNC_READ: begin
                if (!run_active || 32'(in_data.read_index) >= 32'(digits_made) ||
                    32'(in_data.read_index) >= MAX_DIGITS) begin
                  res   <= RES_BAD;
                  state <= S_PUSH;
                end else begin
                  res     <= '0;
                  rd_addr <= DAW'(in_data.read_index);
                  state   <= S_RD_ISSUE;
                end
              end
              default: begin
                res   <= RES_BAD;
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_FILL: begin
          if (32'(fill_addr) == REMAINDER_DEPTH - 1) begin
            state <= S_PUSH;
          end else begin
            fill_addr <= fill_addr + 1'b1;
          end
        end
        S_SW_RD: begin
          state <= S_SW_SUM;
        end
        S_SW_SUM: begin
          quo     <= SW'(rem_rdata) * SW'(10) + carry;
          r       <= '0;
          // the low end divides by ten to give the digit
          modulus <= (j == '0) ? MW'(10) : {j, 1'b1};
          cnt     <= CNW'(SW - 1);
          state   <= S_SW_DIV;
        end
        S_SW_DIV: begin
          r   <= r_ge ? MW'(r_shift - {1'b0, modulus}) : MW'(r_shift);
          quo <= {quo[SW-2:0], r_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_SW_WB;
          end
        end
        S_SW_WB: begin
          if (j == '0) begin
            qd  <= (q_adj > SW'(9)) ? pds_pkg::DIGIT_W'(9) : pds_pkg::DIGIT_W'(q_adj);
            rip <= quo >= SW'(10);
            if (quo >= SW'(10) && pos != '0) begin
              k     <= pos - 1'b1;
              state <= S_RIP_RD;
            end else begin
              state <= S_DIG_WR;
            end
          end else begin
            carry <= SW'(quo * j);
            j     <= j - 1'b1;
            state <= S_SW_RD;
          end
        end
        S_RIP_RD: begin
          state <= S_RIP_WR;
        end
        S_RIP_WR: begin
          // a nine turns to zero and passes the carry on
          if (st_rdata == pds_pkg::DIGIT_W'(9) && k != '0) begin
            k     <= k - 1'b1;
            state <= S_RIP_RD;
          end else begin
            state <= S_DIG_WR;
          end
        end
        S_DIG_WR: begin
          digits_made     <= digits_made + 1'b1;
          res.digit       <= qd;
          res.digit_index <= pds_pkg::IDX_W'(pos);
          res.last_digit  <= (DCW'(pos) + DCW'(1)) == total;
          res.rippled     <= rip;
          state           <= S_PUSH;
        end
        S_RD_ISSUE: begin
          state <= S_RD_TAKE;
        end
        S_RD_TAKE: begin
          res.digit       <= st_rdata;
          res.digit_index <= pds_pkg::IDX_W'(rd_addr);
          res.last_digit  <= (DCW'(rd_addr) + DCW'(1)) == total;
          state           <= S_PUSH;
        end
        S_PUSH: begin
          if (push) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_digits_in_run: assert property (@(posedge clk) disable iff (rst)
    run_active |-> digits_made <= total)
    else $error("digit count beyond run total");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_WB) |-> r < modulus)
    else $error("divider remainder not reduced");

  a_store_decimal: assert property (@(posedge clk) disable iff (rst)
    st_we |-> st_wdata <= pds_pkg::DIGIT_W'(9))
    else $error("non-decimal digit stored");

  a_push_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && (!out_valid || !out_stall)) |=> out_valid)
    else $error("result transaction lost");

endmodule
